// ----- src/packed_pixel_frame_store_core_assert.svh -----
// Assertion macros shared by the frame store RTL.
`ifndef PACKED_PIXEL_FRAME_STORE_CORE_ASSERT_SVH
`define PACKED_PIXEL_FRAME_STORE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PPFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PPFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ppfs_pkg.sv -----
// Shared types, constants and pixel-layout functions of the frame store.
package ppfs_pkg;

    localparam int X_W        = 9;
    localparam int STRIDE_W   = 11;
    localparam int OFS_W      = 11;
    localparam int ADDR_W     = 21;
    localparam int ROW_BITS_W = 14;
    localparam int COLOR_W    = 32;
    localparam int CMDQ_DEPTH = 2;
    localparam int REG_ADDR_W = 4;
    localparam int S_TDATA_W  = 72;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int MEM_BYTES_DEF  = 262144;

    localparam logic [2:0] DEPTH_1  = 3'd0;
    localparam logic [2:0] DEPTH_2  = 3'd1;
    localparam logic [2:0] DEPTH_4  = 3'd2;
    localparam logic [2:0] DEPTH_8  = 3'd3;
    localparam logic [2:0] DEPTH_16 = 3'd4;
    localparam logic [2:0] DEPTH_24 = 3'd5;
    localparam logic [2:0] DEPTH_32 = 3'd6;

    typedef enum logic [1:0] {
        REG_DEPTH  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FILL  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CMD_SKIP  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } cmd_kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROW,
        B_PIX,
        B_ACCESS,
        B_WAIT,
        B_NEXT,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic [2:0]     depth_code;
        logic [X_W-1:0] image_width;
        logic [X_W-1:0] image_height;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [2:0]         depth;
        logic [STRIDE_W-1:0] stride;
        logic [X_W-1:0]     x0;
        logic [X_W-1:0]     x1;
        logic [X_W-1:0]     y0;
        logic [X_W-1:0]     y1;
        logic [COLOR_W-1:0] color;
        logic               flag;
    } cmd_t;

    function automatic logic depth_packed(input logic [2:0] code);
        logic r;
        case (code) inside
            [DEPTH_1:DEPTH_4]: r = 1'b1;
            default:           r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] last_byte(input logic [2:0] code);
        logic [1:0] r;
        case (code) inside
            [DEPTH_1:DEPTH_8]: r = 2'd0;
            DEPTH_16:          r = 2'd1;
            DEPTH_24:          r = 2'd2;
            default:           r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [COLOR_W-1:0] color_mask(input logic [2:0] code);
        logic [COLOR_W-1:0] r;
        case (code)
            DEPTH_1:  r = 32'h0000_0001;
            DEPTH_2:  r = 32'h0000_0003;
            DEPTH_4:  r = 32'h0000_000F;
            DEPTH_8:  r = 32'h0000_00FF;
            DEPTH_16: r = 32'h0000_FFFF;
            DEPTH_24: r = 32'h00FF_FFFF;
            default:  r = 32'hFFFF_FFFF;
        endcase
        return r;
    endfunction

    // Row pitch in bytes, rounded up to whole 32-bit words.
    function automatic logic [STRIDE_W-1:0] row_stride(input logic [2:0] code,
                                                       input logic [X_W-1:0] w);
        logic [ROW_BITS_W-1:0] w_ext;
        logic [ROW_BITS_W-1:0] bits;
        logic [ROW_BITS_W-1:0] rounded;
        w_ext = ROW_BITS_W'(w);
        case (code)
            DEPTH_1:  bits = w_ext;
            DEPTH_2:  bits = w_ext << 1;
            DEPTH_4:  bits = w_ext << 2;
            DEPTH_8:  bits = w_ext << 3;
            DEPTH_16: bits = w_ext << 4;
            DEPTH_24: bits = (w_ext << 4) + (w_ext << 3);
            default:  bits = w_ext << 5;
        endcase
        rounded = bits + ROW_BITS_W'(31);
        return {rounded[ROW_BITS_W-1:5], 2'b00};
    endfunction

    function automatic logic [OFS_W-1:0] byte_offset(input logic [2:0] code,
                                                     input logic [X_W-1:0] x);
        logic [OFS_W-1:0] xe;
        logic [OFS_W-1:0] r;
        xe = OFS_W'(x);
        case (code)
            DEPTH_1:  r = xe >> 3;
            DEPTH_2:  r = xe >> 2;
            DEPTH_4:  r = xe >> 1;
            DEPTH_8:  r = xe;
            DEPTH_16: r = xe << 1;
            DEPTH_24: r = (xe << 1) + xe;
            default:  r = xe << 2;
        endcase
        return r;
    endfunction

    // Left shift of a packed pixel inside its byte, MSB-first order.
    function automatic logic [2:0] bit_shift(input logic [2:0] code,
                                             input logic [X_W-1:0] x);
        logic [2:0] r;
        case (code)
            DEPTH_1: r = 3'd7 - x[2:0];
            DEPTH_2: r = 3'd6 - {x[1:0], 1'b0};
            DEPTH_4: r = x[0] ? 3'd0 : 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/ppfs_ram.sv -----
// Generic single-port RAM with registered read data.
module ppfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/ppfs_front.sv -----
// Front end: accepts request beats, clips them to the image and builds commands.
module ppfs_front #(
    parameter int MAX_WIDTH  = ppfs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ppfs_pkg::MAX_HEIGHT_DEF
) (
    input  ppfs_pkg::cfg_t                 cfg,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ppfs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]                     s_tuser,
    input  logic                           q_full,
    output logic                           push,
    output ppfs_pkg::cmd_t                 cmd
);

    localparam int XW = ppfs_pkg::X_W;

    logic [7:0]                      pos_x;
    logic [7:0]                      pos_y;
    logic [XW-1:0]                   rect_width;
    logic [XW-1:0]                   rect_height;
    logic [ppfs_pkg::COLOR_W-1:0]    pixel_color;
    logic [XW-1:0]                   eff_w;
    logic [XW-1:0]                   eff_h;
    logic [XW:0]                     x_end_raw;
    logic [XW:0]                     y_end_raw;

    assign pos_x       = s_tdata[7:0];
    assign pos_y       = s_tdata[15:8];
    assign rect_width  = s_tdata[24:16];
    assign rect_height = s_tdata[33:25];
    assign pixel_color = s_tdata[65:34];

    assign eff_w = (int'(cfg.image_width) > MAX_WIDTH) ? XW'(MAX_WIDTH) : cfg.image_width;
    assign eff_h = (int'(cfg.image_height) > MAX_HEIGHT) ? XW'(MAX_HEIGHT) : cfg.image_height;

    assign x_end_raw = (XW+1)'(pos_x) + (XW+1)'(rect_width);
    assign y_end_raw = (XW+1)'(pos_y) + (XW+1)'(rect_height);

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb
    begin
        cmd        = '0;
        cmd.kind   = ppfs_pkg::CMD_SKIP;
        cmd.depth  = cfg.depth_code;
        cmd.stride = ppfs_pkg::row_stride(cfg.depth_code, eff_w);
        cmd.color  = pixel_color & ppfs_pkg::color_mask(cfg.depth_code);
        cmd.x0     = XW'(pos_x);
        cmd.y0     = XW'(pos_y);
        cmd.x1     = XW'(pos_x) + XW'(1);
        cmd.y1     = XW'(pos_y) + XW'(1);
        cmd.flag   = 1'b0;
        case (ppfs_pkg::action_t'(s_tuser))
            ppfs_pkg::ACT_READ, ppfs_pkg::ACT_WRITE:
            begin
                if (cmd.x0 >= eff_w || cmd.y0 >= eff_h)
                begin
                    cmd.flag = 1'b1;
                end
                else
                begin
                    cmd.kind = (ppfs_pkg::action_t'(s_tuser) == ppfs_pkg::ACT_READ) ?
                               ppfs_pkg::CMD_READ : ppfs_pkg::CMD_WRITE;
                end
            end
            ppfs_pkg::ACT_FILL:
            begin
                if (rect_width != '0 && rect_height != '0)
                begin
                    cmd.flag = (x_end_raw > (XW+1)'(eff_w)) || (y_end_raw > (XW+1)'(eff_h));
                    cmd.x1 = (x_end_raw > (XW+1)'(eff_w)) ? eff_w : x_end_raw[XW-1:0];
                    cmd.y1 = (y_end_raw > (XW+1)'(eff_h)) ? eff_h : y_end_raw[XW-1:0];
                    if (cmd.x0 < cmd.x1 && cmd.y0 < cmd.y1)
                    begin
                        cmd.kind = ppfs_pkg::CMD_WRITE;
                    end
                end
            end
            default:
            begin
                cmd.kind = ppfs_pkg::CMD_SKIP;
            end
        endcase
    end

endmodule

// ----- src/ppfs_cmdq.sv -----
// Short command queue between the front and back ends.
`include "packed_pixel_frame_store_core_assert.svh"

module ppfs_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ppfs_pkg::cmd_t push_data,
    input  logic           pop,
    output ppfs_pkg::cmd_t pop_data,
    output logic           full,
    output logic           empty
);

    localparam int DEPTH = ppfs_pkg::CMDQ_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    ppfs_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `PPFS_ASSERT_IMP(a_pop_not_empty, clk, rst_n, pop, count_reg != '0, "pop from empty queue")
    `PPFS_ASSERT_IMP(a_push_room, clk, rst_n, push && !pop, count_reg < CW'(DEPTH), "push to full queue")

endmodule

// ----- src/ppfs_back.sv -----
// Back end: walks each command's pixels over the byte RAM and returns one result beat.
`include "packed_pixel_frame_store_core_assert.svh"

module ppfs_back #(
    parameter int MEM_BYTES = ppfs_pkg::MEM_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  ppfs_pkg::cmd_t q_data,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata,
    output logic [0:0]     m_tuser
);

    localparam int XW     = ppfs_pkg::X_W;
    localparam int AW     = ppfs_pkg::ADDR_W;
    localparam int RAM_AW = $clog2(MEM_BYTES);

    ppfs_pkg::back_state_t        state_reg;
    ppfs_pkg::back_state_t        state_next;
    ppfs_pkg::cmd_t               cmd_reg;
    ppfs_pkg::cmd_t               cmd_next;
    logic [XW-1:0]                x_reg;
    logic [XW-1:0]                x_next;
    logic [XW-1:0]                y_reg;
    logic [XW-1:0]                y_next;
    logic [AW-1:0]                row_base_reg;
    logic [AW-1:0]                row_base_next;
    logic [AW-1:0]                addr_reg;
    logic [AW-1:0]                addr_next;
    logic [2:0]                   sh_reg;
    logic [2:0]                   sh_next;
    logic [1:0]                   k_reg;
    logic [1:0]                   k_next;
    logic [31:0]                  value_reg;
    logic [31:0]                  value_next;
    logic                         rd_pend_reg;
    logic                         rd_pend_next;
    logic [1:0]                   rd_lane_reg;
    logic [1:0]                   rd_lane_next;
    logic                         rd_oob_reg;
    logic                         rd_oob_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [31:0]                  out_value_reg;
    logic [31:0]                  out_value_next;
    logic                         out_flag_reg;
    logic                         out_flag_next;

    logic                         packed_mode;
    logic [1:0]                   last_k;
    logic [ppfs_pkg::COLOR_W-1:0] mask_full;
    logic [7:0]                   pmask;
    logic [7:0]                   wmask;
    logic [7:0]                   q_byte;
    logic [7:0]                   merged;
    logic [AW-1:0]                cur_addr;
    logic                         cur_oob;
    logic [XW+ppfs_pkg::STRIDE_W-1:0] row_product;
    logic                         ram_we;
    logic [7:0]                   ram_wdata;
    logic [7:0]                   ram_rdata;

    assign packed_mode = ppfs_pkg::depth_packed(cmd_reg.depth);
    assign last_k      = ppfs_pkg::last_byte(cmd_reg.depth);
    assign mask_full   = ppfs_pkg::color_mask(cmd_reg.depth);
    assign pmask       = mask_full[7:0];
    assign wmask       = pmask << sh_reg;
    assign q_byte      = rd_oob_reg ? 8'd0 : ram_rdata;
    assign merged      = (q_byte & ~wmask) | ((cmd_reg.color[7:0] << sh_reg) & wmask);
    assign cur_addr    = addr_reg + AW'(k_reg);
    assign cur_oob     = 32'(cur_addr) >= 32'(MEM_BYTES);
    assign row_product = y_reg * cmd_reg.stride;

    ppfs_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .clk   (clk),
        .addr  (RAM_AW'(cur_addr)),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        row_base_next  = row_base_reg;
        addr_next      = addr_reg;
        sh_next        = sh_reg;
        k_next         = k_reg;
        value_next     = value_reg;
        rd_pend_next   = 1'b0;
        rd_lane_next   = k_reg;
        rd_oob_next    = cur_oob;
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_flag_next  = out_flag_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = cmd_reg.color[{k_reg, 3'b000} +: 8];

        if (rd_pend_reg && !packed_mode)
        begin
            value_next[{rd_lane_reg, 3'b000} +: 8] = q_byte;
        end

        case (state_reg)
            ppfs_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    x_next     = q_data.x0;
                    y_next     = q_data.y0;
                    value_next = '0;
                    state_next = (q_data.kind == ppfs_pkg::CMD_SKIP) ?
                                 ppfs_pkg::B_DONE : ppfs_pkg::B_ROW;
                end
            end
            ppfs_pkg::B_ROW:
            begin
                row_base_next = AW'(row_product);
                state_next    = ppfs_pkg::B_PIX;
            end
            ppfs_pkg::B_PIX:
            begin
                addr_next  = row_base_reg + AW'(ppfs_pkg::byte_offset(cmd_reg.depth, x_reg));
                sh_next    = ppfs_pkg::bit_shift(cmd_reg.depth, x_reg);
                k_next     = '0;
                state_next = ppfs_pkg::B_ACCESS;
            end
            ppfs_pkg::B_ACCESS:
            begin
                if (packed_mode)
                begin
                    rd_pend_next = 1'b1;
                    state_next   = ppfs_pkg::B_WAIT;
                end
                else if (cmd_reg.kind == ppfs_pkg::CMD_READ)
                begin
                    rd_pend_next = 1'b1;
                    if (k_reg == last_k)
                    begin
                        state_next = ppfs_pkg::B_WAIT;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
                else
                begin
                    ram_we = !cur_oob;
                    if (k_reg == last_k)
                    begin
                        state_next = ppfs_pkg::B_NEXT;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            ppfs_pkg::B_WAIT:
            begin
                if (packed_mode)
                begin
                    if (cmd_reg.kind == ppfs_pkg::CMD_READ)
                    begin
                        value_next = 32'((q_byte >> sh_reg) & pmask);
                        state_next = ppfs_pkg::B_DONE;
                    end
                    else
                    begin
                        ram_we     = !cur_oob;
                        ram_wdata  = merged;
                        state_next = ppfs_pkg::B_NEXT;
                    end
                end
                else
                begin
                    state_next = ppfs_pkg::B_DONE;
                end
            end
            ppfs_pkg::B_NEXT:
            begin
                if ((x_reg + XW'(1)) < cmd_reg.x1)
                begin
                    x_next     = x_reg + XW'(1);
                    state_next = ppfs_pkg::B_PIX;
                end
                else if ((y_reg + XW'(1)) < cmd_reg.y1)
                begin
                    x_next     = cmd_reg.x0;
                    y_next     = y_reg + XW'(1);
                    state_next = ppfs_pkg::B_ROW;
                end
                else
                begin
                    state_next = ppfs_pkg::B_DONE;
                end
            end
            ppfs_pkg::B_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = value_reg;
                    out_flag_next  = cmd_reg.flag;
                    state_next     = ppfs_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = ppfs_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppfs_pkg::B_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        row_base_reg  <= row_base_next;
        addr_reg      <= addr_next;
        sh_reg        <= sh_next;
        k_reg         <= k_next;
        value_reg     <= value_next;
        rd_lane_reg   <= rd_lane_next;
        rd_oob_reg    <= rd_oob_next;
        out_value_reg <= out_value_next;
        out_flag_reg  <= out_flag_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_flag_reg;

    `PPFS_ASSERT_IMP(a_we_on_write, clk, rst_n, ram_we, cmd_reg.kind == ppfs_pkg::CMD_WRITE, "RAM write outside a write command")
    `PPFS_ASSERT_IMP(a_rd_in_access, clk, rst_n, rd_pend_reg, (state_reg == ppfs_pkg::B_ACCESS) || (state_reg == ppfs_pkg::B_WAIT), "read data landed outside a pixel access")
    `PPFS_ASSERT_NXT(a_result_loaded, clk, rst_n, (state_reg == ppfs_pkg::B_DONE) && (!out_valid_reg || m_tready), out_valid_reg, "finished command gave no result beat")

endmodule

// ----- src/packed_pixel_frame_store_core.sv -----
// Top level of the packed-pixel frame store: register file, front end, queue, back end.
//
// Byte-addressed image store in the BMP row layout (rows padded to 4 bytes; depths of
// 1, 2 and 4 bits packed MSB first, wider depths little-endian). Request beats carry a
// pixel read, a pixel write or a rectangle fill; every beat gives exactly one result
// beat. A front end clips the request to the image and queues it (two entries), and a
// back end walks the pixels over one single-port byte RAM, at most one access per cycle.
// Per item the back end steps through dispatch, then per row touched a row-base step,
// then per pixel an address step, the byte accesses (one at 1, 2 or 4 bits, else one
// per byte) and a step for the read data or to the next pixel; a packed write adds a
// step merging its byte. Last comes the result step. A request that touches nothing
// goes straight from dispatch to the result. The store is not cleared at reset: a
// byte holds nothing defined until written. Configuration must be written over the
// APB port only while the block is idle; the block itself does not enforce this.
module packed_pixel_frame_store_core #(
    parameter int MAX_WIDTH  = ppfs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ppfs_pkg::MAX_HEIGHT_DEF,
    parameter int MEM_BYTES  = ppfs_pkg::MEM_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppfs_pkg::REG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x[7:0], pos_y[15:8], rect_width[24:16], rect_height[33:25], pixel_color[65:34]
    input  logic [ppfs_pkg::S_TDATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_value[31:0]
    output logic [31:0]                     m_tdata,
    // off_image[0]
    output logic [0:0]                      m_tuser
);

    logic [2:0]              depth_code_reg;
    logic [ppfs_pkg::X_W-1:0] image_width_reg;
    logic [ppfs_pkg::X_W-1:0] image_height_reg;
    ppfs_pkg::reg_index_t    reg_sel;
    logic                    cfg_write;
    ppfs_pkg::cfg_t          cfg;
    logic                    push;
    ppfs_pkg::cmd_t          push_cmd;
    logic                    q_full;
    logic                    q_empty;
    logic                    q_pop;
    ppfs_pkg::cmd_t          q_data;

    assign pready    = 1'b1;
    assign reg_sel   = ppfs_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_code_reg   <= ppfs_pkg::DEPTH_8;
            image_width_reg  <= ppfs_pkg::X_W'(256);
            image_height_reg <= ppfs_pkg::X_W'(256);
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                ppfs_pkg::REG_DEPTH:  depth_code_reg   <= pwdata[2:0];
                ppfs_pkg::REG_WIDTH:  image_width_reg  <= pwdata[ppfs_pkg::X_W-1:0];
                ppfs_pkg::REG_HEIGHT: image_height_reg <= pwdata[ppfs_pkg::X_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            ppfs_pkg::REG_DEPTH:  prdata = 32'(depth_code_reg);
            ppfs_pkg::REG_WIDTH:  prdata = 32'(image_width_reg);
            ppfs_pkg::REG_HEIGHT: prdata = 32'(image_height_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.depth_code   = depth_code_reg;
    assign cfg.image_width  = image_width_reg;
    assign cfg.image_height = image_height_reg;

    ppfs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    ppfs_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    ppfs_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- verif/packed_pixel_frame_store_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the packed-pixel frame store: directed table, then random phases.
module packed_pixel_frame_store_core_tb;

    localparam logic [1:0] ACT_NONE         = 2'd3;
    localparam logic [2:0] DEPTH_CODE_SPARE = 3'd7;
    localparam int         PHASES           = 8;
    localparam int         ITEMS_PER_PHASE  = 250;
    localparam int         CYCLE_LIMIT      = 5000000;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [8:0]  rw;
        logic [8:0]  rh;
        logic [31:0] color;
    } frame_req_t;

    typedef struct packed {
        logic [31:0] value;
        logic        oor;
    } frame_result_t;

    typedef struct {
        bit                   is_cfg;
        ppfs_pkg::reg_index_t reg_idx;
        logic [8:0]           reg_val;
        frame_req_t           req;
        bit                   typed;
        frame_result_t        want;
    } dir_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [ppfs_pkg::REG_ADDR_W-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ppfs_pkg::S_TDATA_W-1:0]  s_tdata;
    logic [1:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [31:0]                     m_tdata;
    logic [0:0]                      m_tuser;

    packed_pixel_frame_store_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predictor state
    logic [7:0]    frame_mem [ppfs_pkg::MEM_BYTES_DEF];
    logic [2:0]    cfg_depth;
    logic [8:0]    cfg_width;
    logic [8:0]    cfg_height;
    frame_result_t expected_q [$];
    dir_row_t      dir_tab [$];

    int err_cnt;
    int cycle_cnt;
    int n_read;
    int n_write;
    int n_fill;
    int n_none;
    int n_oor;
    int n_cfg;
    bit no_idle;
    int unsigned last_x;
    int unsigned last_y;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned px_bits(logic [2:0] code);
        case (code)
            ppfs_pkg::DEPTH_1:  return 1;
            ppfs_pkg::DEPTH_2:  return 2;
            ppfs_pkg::DEPTH_4:  return 4;
            ppfs_pkg::DEPTH_8:  return 8;
            ppfs_pkg::DEPTH_16: return 16;
            ppfs_pkg::DEPTH_24: return 24;
            default:            return 32;
        endcase
    endfunction

    function automatic int unsigned eff_dim(logic [8:0] v, int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic int unsigned px_addr(int unsigned x, int unsigned y);
        int unsigned bpp;
        int unsigned stride;
        bpp = px_bits(cfg_depth);
        stride = ((bpp * eff_dim(cfg_width, ppfs_pkg::MAX_WIDTH_DEF) + 31) / 32) * 4;
        return y * stride + (x * bpp) / 8;
    endfunction

    function automatic logic [7:0] mem_rd(int unsigned addr);
        return (addr < ppfs_pkg::MEM_BYTES_DEF) ? frame_mem[addr] : 8'h00;
    endfunction

    function automatic void px_put(int unsigned x, int unsigned y, logic [31:0] color);
        int unsigned bpp;
        int unsigned addr;
        int unsigned sh;
        logic [31:0] msk;
        logic [31:0] b;
        bpp = px_bits(cfg_depth);
        addr = px_addr(x, y);
        if (bpp < 8)
        begin
            sh = 8 - bpp * (1 + x % (8 / bpp));
            msk = ((32'd1 << bpp) - 1) << sh;
            b = {24'h0, mem_rd(addr)};
            b = (b & ~msk) | ((color << sh) & msk);
            if (addr < ppfs_pkg::MEM_BYTES_DEF)
                frame_mem[addr] = b[7:0];
        end
        else
        begin
            for (int k = 0; k < bpp / 8; k++)
                if (addr + k < ppfs_pkg::MEM_BYTES_DEF)
                    frame_mem[addr + k] = color[8*k +: 8];
        end
    endfunction

    function automatic frame_result_t frame_predict(frame_req_t r);
        frame_result_t res;
        int unsigned bpp;
        int unsigned w;
        int unsigned h;
        int unsigned addr;
        int unsigned sh;
        int unsigned xe;
        int unsigned ye;
        logic [31:0] color;
        res = '0;
        bpp = px_bits(cfg_depth);
        w = eff_dim(cfg_width, ppfs_pkg::MAX_WIDTH_DEF);
        h = eff_dim(cfg_height, ppfs_pkg::MAX_HEIGHT_DEF);
        color = (bpp < 32) ? (r.color & ((32'd1 << bpp) - 1)) : r.color;
        if (r.action == ppfs_pkg::ACT_READ || r.action == ppfs_pkg::ACT_WRITE)
        begin
            if (r.x >= w || r.y >= h)
                res.oor = 1'b1;
            else if (r.action == ppfs_pkg::ACT_READ)
            begin
                addr = px_addr(r.x, r.y);
                if (bpp < 8)
                begin
                    sh = 8 - bpp * (1 + r.x % (8 / bpp));
                    res.value = ({24'h0, mem_rd(addr)} >> sh) & ((32'd1 << bpp) - 1);
                end
                else
                begin
                    for (int k = 0; k < bpp / 8; k++)
                        res.value |= {24'h0, mem_rd(addr + k)} << (8 * k);
                end
            end
            else
                px_put(r.x, r.y, color);
        end
        else if (r.action == ppfs_pkg::ACT_FILL && r.rw != 0 && r.rh != 0)
        begin
            xe = r.x + r.rw;
            ye = r.y + r.rh;
            if (xe > w || ye > h)
                res.oor = 1'b1;
            if (xe > w)
                xe = w;
            if (ye > h)
                ye = h;
            for (int unsigned yy = r.y; yy < ye; yy++)
                for (int unsigned xx = r.x; xx < xe; xx++)
                    px_put(xx, yy, color);
        end
        return res;
    endfunction

    function automatic dir_row_t dir_cfg(ppfs_pkg::reg_index_t idx, logic [8:0] val);
        dir_row_t row;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        row.req     = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic dir_row_t dir_item(logic [1:0] act, logic [7:0] x, logic [7:0] y,
                                          logic [8:0] rw, logic [8:0] rh, logic [31:0] color,
                                          bit typed, logic [31:0] val, logic oor);
        dir_row_t row;
        row.is_cfg  = 1'b0;
        row.reg_idx = ppfs_pkg::REG_DEPTH;
        row.reg_val = '0;
        row.req = '{action: act, x: x, y: y, rw: rw, rh: rh, color: color};
        row.typed = typed;
        row.want = '{value: val, oor: oor};
        return row;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 85)
            return $urandom_range(1, 3);
        else if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [8:0] pick_dim();
        int unsigned p;
        p = $urandom_range(0, 49);
        if (p < 35)
            return 9'($urandom_range(1, 256));
        else if (p < 40)
            return 9'd256;
        else if (p < 44)
            return 9'd1;
        else if (p < 46)
            return 9'd0;
        return 9'($urandom_range(257, 511));
    endfunction

    // near the last write, inside or just past the edge, or anywhere
    function automatic logic [7:0] pick_coord(int unsigned last, int unsigned span);
        int unsigned p;
        int unsigned v;
        p = $urandom_range(0, 9);
        if (p < 4)
        begin
            v = last + $urandom_range(0, 2);
            v = (v == 0) ? 0 : v - 1;
            if (v > 255)
                v = 255;
        end
        else if (p < 9)
            v = $urandom_range(0, (span > 255) ? 255 : span);
        else
            v = $urandom_range(0, 255);
        return v[7:0];
    endfunction

    task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h want %h (cycle %0d)", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    // APB write, then read back the same register
    task automatic reg_write(ppfs_pkg::reg_index_t idx, logic [8:0] val);
        logic [31:0] want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            ppfs_pkg::REG_DEPTH: cfg_depth  = val[2:0];
            ppfs_pkg::REG_WIDTH: cfg_width  = val;
            default:             cfg_height = val;
        endcase
        want = (idx == ppfs_pkg::REG_DEPTH) ? {29'h0, val[2:0]} : {23'h0, val};
        n_cfg++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            note_mismatch("register readback", prdata, want);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_req(frame_req_t r, bit typed, frame_result_t want);
        frame_result_t got;
        int unsigned g;
        g = no_idle ? 0 : gap_len();
        @(negedge clk);
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'h0, r.color, r.rh, r.rw, r.y, r.x};
        s_tuser  <= r.action;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        got = frame_predict(r);
        expected_q.push_back(typed ? want : got);
        case (r.action)
            ppfs_pkg::ACT_READ:  n_read++;
            ppfs_pkg::ACT_WRITE: n_write++;
            ppfs_pkg::ACT_FILL:  n_fill++;
            default:             n_none++;
        endcase
        if (got.oor)
            n_oor++;
    endtask

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_q.size());
            $display("packed_pixel_frame_store_core_tb: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (expected_q.size() == 0)
                note_mismatch("result beat with nothing pending", m_tdata, 32'h0);
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata !== want.value)
                    note_mismatch("read_value", m_tdata, want.value);
                if (m_tuser[0] !== want.oor)
                    note_mismatch("off_image", {31'h0, m_tuser[0]}, {31'h0, want.oor});
            end
        end
    end

    initial
    begin
        int unsigned hold;
        hold = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 2) == 0)
                    hold = gap_len();
            end
        end
    end

    initial
    begin
        frame_req_t r;
        int unsigned p;
        int unsigned w;
        int unsigned h;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        err_cnt  = 0;
        cycle_cnt = 0;
        n_read = 0;
        n_write = 0;
        n_fill = 0;
        n_none = 0;
        n_oor = 0;
        n_cfg = 0;
        no_idle = 1'b0;
        last_x = 0;
        last_y = 0;
        cfg_depth  = ppfs_pkg::DEPTH_8;
        cfg_width  = 9'd256;
        cfg_height = 9'd256;
        for (int i = 0; i < ppfs_pkg::MEM_BYTES_DEF; i++)
            frame_mem[i] = 8'h00;

        // reset geometry; then a full-size 32-bit fill defines every byte of the store
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_FILL, 8'd200, 8'd0, 9'd100, 9'd1, 32'h1FF,
                                   1, 0, 1));
        dir_tab.push_back(dir_cfg(ppfs_pkg::REG_DEPTH, 9'(ppfs_pkg::DEPTH_32)));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_FILL, 8'd0, 8'd0, 9'd256, 9'd256,
                                   32'h1357_9BDF, 1, 0, 0));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_READ, 8'd255, 8'd255, 9'd0, 9'd0, 32'h0,
                                   1, 32'h1357_9BDF, 0));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_WRITE, 8'd0, 8'd0, 9'd0, 9'd0,
                                   32'hFFFF_FFFF, 1, 0, 0));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_READ, 8'd0, 8'd0, 9'd0, 9'd0, 32'h0,
                                   1, 32'hFFFF_FFFF, 0));
        dir_tab.push_back(dir_item(ACT_NONE, 8'd255, 8'd255, 9'd511, 9'd511, 32'hFFFF_FFFF,
                                   1, 0, 0));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_FILL, 8'd10, 8'd10, 9'd0, 9'd5, 32'h0,
                                   1, 0, 0));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_FILL, 8'd10, 8'd10, 9'd5, 9'd0, 32'h0,
                                   1, 0, 0));
        dir_tab.push_back(dir_cfg(ppfs_pkg::REG_WIDTH, 9'd100));
        dir_tab.push_back(dir_cfg(ppfs_pkg::REG_HEIGHT, 9'd50));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_READ, 8'd100, 8'd10, 9'd0, 9'd0, 32'h0,
                                   1, 0, 1));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_READ, 8'd10, 8'd50, 9'd0, 9'd0, 32'h0,
                                   1, 0, 1));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_WRITE, 8'd100, 8'd0, 9'd0, 9'd0, 32'h1,
                                   1, 0, 1));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_WRITE, 8'd99, 8'd49, 9'd0, 9'd0,
                                   32'h2468_ACE0, 0, 0, 0));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_FILL, 8'd90, 8'd45, 9'd20, 9'd10,
                                   32'h0F0F_0F0F, 1, 0, 1));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_READ, 8'd99, 8'd49, 9'd0, 9'd0, 32'h0,
                                   0, 0, 0));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_READ, 8'd89, 8'd44, 9'd0, 9'd0, 32'h0,
                                   0, 0, 0));
        dir_tab.push_back(dir_cfg(ppfs_pkg::REG_DEPTH, 9'(ppfs_pkg::DEPTH_1)));
        dir_tab.push_back(dir_cfg(ppfs_pkg::REG_WIDTH, 9'd256));
        dir_tab.push_back(dir_cfg(ppfs_pkg::REG_HEIGHT, 9'd256));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_WRITE, 8'd3, 8'd7, 9'd0, 9'd0,
                                   32'hFFFF_FFFF, 0, 0, 0));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_READ, 8'd3, 8'd7, 9'd0, 9'd0, 32'h0,
                                   0, 0, 0));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_READ, 8'd4, 8'd7, 9'd0, 9'd0, 32'h0,
                                   0, 0, 0));
        dir_tab.push_back(dir_cfg(ppfs_pkg::REG_DEPTH, 9'(DEPTH_CODE_SPARE)));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_READ, 8'd255, 8'd255, 9'd0, 9'd0, 32'h0,
                                   0, 0, 0));
        dir_tab.push_back(dir_cfg(ppfs_pkg::REG_WIDTH, 9'd0));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_READ, 8'd0, 8'd0, 9'd0, 9'd0, 32'h0,
                                   1, 0, 1));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_FILL, 8'd0, 8'd0, 9'd1, 9'd1, 32'h5,
                                   1, 0, 1));
        dir_tab.push_back(dir_cfg(ppfs_pkg::REG_WIDTH, 9'd511));
        dir_tab.push_back(dir_cfg(ppfs_pkg::REG_HEIGHT, 9'd511));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_WRITE, 8'd255, 8'd255, 9'd0, 9'd0,
                                   32'hCAFE_0001, 0, 0, 0));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_READ, 8'd255, 8'd255, 9'd0, 9'd0, 32'h0,
                                   0, 0, 0));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_FILL, 8'd255, 8'd255, 9'd511, 9'd511,
                                   32'h0, 1, 0, 1));
        dir_tab.push_back(dir_item(ppfs_pkg::ACT_READ, 8'd255, 8'd255, 9'd0, 9'd0, 32'h0,
                                   0, 0, 0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                drain_results();
                reg_write(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end
            else
                send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
        end

        // one phase per depth code, random geometry
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            no_idle = ($urandom_range(0, 3) == 0);
            reg_write(ppfs_pkg::REG_DEPTH, 9'(ph));
            reg_write(ppfs_pkg::REG_WIDTH, pick_dim());
            reg_write(ppfs_pkg::REG_HEIGHT, pick_dim());
            w = eff_dim(cfg_width, ppfs_pkg::MAX_WIDTH_DEF);
            h = eff_dim(cfg_height, ppfs_pkg::MAX_HEIGHT_DEF);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                p = $urandom_range(0, 19);
                r.action = (p < 8) ? ppfs_pkg::ACT_READ : (p < 14) ? ppfs_pkg::ACT_WRITE :
                           (p < 19) ? ppfs_pkg::ACT_FILL : ACT_NONE;
                r.x = pick_coord(last_x, w);
                r.y = pick_coord(last_y, h);
                r.color = $urandom;
                if (r.action == ppfs_pkg::ACT_FILL)
                begin
                    p = $urandom_range(0, 99);
                    if (p == 0)
                    begin
                        r.rw = 9'($urandom_range(0, 511));
                        r.rh = 9'($urandom_range(1, 3));
                    end
                    else if (p == 1)
                    begin
                        r.rw = 9'($urandom_range(1, 3));
                        r.rh = 9'($urandom_range(0, 511));
                    end
                    else
                    begin
                        r.rw = 9'($urandom_range(0, 6));
                        r.rh = 9'($urandom_range(0, 6));
                    end
                end
                else
                begin
                    r.rw = 9'($urandom_range(0, 511));
                    r.rh = 9'($urandom_range(0, 511));
                end
                if (r.action == ppfs_pkg::ACT_WRITE || r.action == ppfs_pkg::ACT_FILL)
                begin
                    last_x = r.x;
                    last_y = r.y;
                end
                send_req(r, 1'b0, '0);
            end
        end

        drain_results();
        repeat (16) @(posedge clk);
        $display("covered %0d reads, %0d writes, %0d fills, %0d unused-action beats, %0d flagged",
                 n_read, n_write, n_fill, n_none, n_oor);
        $display("over %0d register writes: all eight depth codes, geometry from 0 to 511",
                 n_cfg);
        if (err_cnt == 0 && expected_q.size() == 0)
            $display("packed_pixel_frame_store_core_tb: done, clean");
        else
            $display("packed_pixel_frame_store_core_tb: done, errors");
        $finish;
    end

endmodule
